// File: rtl/ciw_pkg.sv
package ciw_pkg;

  localparam int unsigned CodeW = 4;
  localparam int unsigned LenW  = 28;
  localparam int unsigned PosW  = 31;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // per-code consumption masks, bit n set when code n moves the position
  localparam logic [15:0] QueryMoveMask = 16'h0193;
  localparam logic [15:0] RefMoveMask   = 16'h018D;

  localparam logic [CodeW-1:0] CodeHardClip = 4'd5;
  localparam logic [CodeW-1:0] CodeSoftClip = 4'd4;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_WALK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_WALK  = 2'd2
  } kind_e;

  // classified work word passed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [CodeW-1:0]  op_code;
    logic [LenW-1:0]   op_length;
    logic [PosW-1:0]   ref_val;   // begin: ref start, walk: ref advance
    logic [PosW-1:0]   qry_val;   // begin: query start, count/walk: query advance
    logic              reverse;
  } entry_t;

  typedef struct packed {
    logic [CodeW-1:0] op_code;
    logic [LenW-1:0]  op_length;
    logic [PosW-1:0]  ref_from;
    logic [PosW-1:0]  ref_to;
    logic [PosW-1:0]  query_from;
    logic [PosW-1:0]  query_to;
    logic             strand_reverse;
  } result_t;

endpackage

// File: rtl/ciw_front.sv
module ciw_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 cmd_i,
  input  logic [31:0]                cigar_word_i,
  input  logic [ciw_pkg::PosW-1:0]   align_ref_start_i,
  input  logic                       align_reverse_i,
  input  logic                       unclip_mode_i,
  input  logic [ciw_pkg::PosW-1:0]   read_length_i,
  output logic                       keep_o,
  output ciw_pkg::entry_t            entry_o
);

  logic reverse_q, reverse_d;
  logic unclip_q, unclip_d;
  logic [ciw_pkg::CodeW-1:0] code_raw;
  logic [ciw_pkg::CodeW-1:0] code_walk;
  logic [ciw_pkg::LenW-1:0]  len;
  logic [ciw_pkg::PosW-1:0]  len_ext;
  logic                      q_move_raw;
  logic                      q_move_walk;
  logic                      r_move_walk;

  assign code_raw    = cigar_word_i[ciw_pkg::CodeW-1:0];
  assign len         = cigar_word_i[31:ciw_pkg::CodeW];
  assign len_ext     = {{(ciw_pkg::PosW-ciw_pkg::LenW){1'b0}}, len};
  // hard clip reads as soft clip in unclip mode
  assign code_walk   = (unclip_q && code_raw == ciw_pkg::CodeHardClip) ?
                       ciw_pkg::CodeSoftClip : code_raw;
  assign q_move_raw  = ciw_pkg::QueryMoveMask[code_raw] ||
                       (code_raw == ciw_pkg::CodeHardClip);
  assign q_move_walk = ciw_pkg::QueryMoveMask[code_walk];
  assign r_move_walk = ciw_pkg::RefMoveMask[code_walk];

  always_comb begin
    reverse_d         = reverse_q;
    unclip_d          = unclip_q;
    keep_o            = 1'b0;
    entry_o.kind      = ciw_pkg::KIND_WALK;
    entry_o.op_code   = code_walk;
    entry_o.op_length = len;
    entry_o.ref_val   = '0;
    entry_o.qry_val   = '0;
    entry_o.reverse   = reverse_q;
    unique case (ciw_pkg::cmd_e'(cmd_i))
      ciw_pkg::CMD_BEGIN: begin
        keep_o          = 1'b1;
        reverse_d       = align_reverse_i;
        unclip_d        = unclip_mode_i;
        entry_o.kind    = ciw_pkg::KIND_BEGIN;
        entry_o.ref_val = align_ref_start_i;
        entry_o.qry_val = (align_reverse_i && !unclip_mode_i) ? read_length_i : '0;
        entry_o.reverse = align_reverse_i;
      end
      ciw_pkg::CMD_COUNT: begin
        // only the reverse unclip pre-pass moves anything
        keep_o          = reverse_q && unclip_q && q_move_raw && (len != '0);
        entry_o.kind    = ciw_pkg::KIND_COUNT;
        entry_o.qry_val = len_ext;
      end
      ciw_pkg::CMD_WALK: begin
        keep_o          = 1'b1;
        entry_o.kind    = ciw_pkg::KIND_WALK;
        entry_o.ref_val = r_move_walk ? len_ext : '0;
        entry_o.qry_val = q_move_walk ? len_ext : '0;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
    if (!accept_i) begin
      reverse_d = reverse_q;
      unclip_d  = unclip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
      unclip_q  <= 1'b0;
    end else begin
      reverse_q <= reverse_d;
      unclip_q  <= unclip_d;
    end
  end

endmodule

// File: rtl/ciw_queue.sv
module ciw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ciw_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ciw_pkg::entry_t entry_o
);

  ciw_pkg::entry_t store_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = store_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 3'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/ciw_back.sv
module ciw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  ciw_pkg::entry_t  entry_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ciw_pkg::result_t res_o
);

  logic [ciw_pkg::PosW-1:0] ref_q, ref_d;
  logic [ciw_pkg::PosW-1:0] qry_q, qry_d;
  logic [ciw_pkg::PosW:0]   q_sum, r_sum;
  logic [ciw_pkg::PosW-1:0] q_add, q_sub, r_add, q_stop;
  logic                     is_walk, exec, res_pop, res_push;
  ciw_pkg::result_t         res_d;

  ciw_pkg::result_t res_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;

  assign empty_o = (res_cnt_q == 2'd0);
  assign res_pop = pop_i && !empty_o;
  assign res_o   = res_q[res_rd_q];

  assign is_walk  = (entry_i.kind == ciw_pkg::KIND_WALK);
  // a walk needs a free result slot, other words never stall
  assign exec     = !q_empty_i && (!is_walk || res_cnt_q != 2'd2 || res_pop);
  assign q_pop_o  = exec;
  assign res_push = exec && is_walk;

  // saturating position arithmetic
  assign q_sum = {1'b0, qry_q} + {1'b0, entry_i.qry_val};
  assign r_sum = {1'b0, ref_q} + {1'b0, entry_i.ref_val};
  assign q_add = q_sum[ciw_pkg::PosW] ? ciw_pkg::PosMax : q_sum[ciw_pkg::PosW-1:0];
  assign r_add = r_sum[ciw_pkg::PosW] ? ciw_pkg::PosMax : r_sum[ciw_pkg::PosW-1:0];
  assign q_sub = (entry_i.qry_val >= qry_q) ? '0 : (qry_q - entry_i.qry_val);
  assign q_stop = entry_i.reverse ? q_sub : q_add;

  always_comb begin
    ref_d = ref_q;
    qry_d = qry_q;
    res_d.op_code        = entry_i.op_code;
    res_d.op_length      = entry_i.op_length;
    res_d.ref_from       = ref_q;
    res_d.ref_to         = r_add;
    res_d.query_from     = entry_i.reverse ? q_stop : qry_q;
    res_d.query_to       = entry_i.reverse ? qry_q : q_stop;
    res_d.strand_reverse = entry_i.reverse;
    if (exec) begin
      case (entry_i.kind)
        ciw_pkg::KIND_BEGIN: begin
          ref_d = entry_i.ref_val;
          qry_d = entry_i.qry_val;
        end
        ciw_pkg::KIND_COUNT: begin
          qry_d = q_add;
        end
        ciw_pkg::KIND_WALK: begin
          ref_d = r_add;
          qry_d = q_stop;
        end
        default: begin
          ref_d = ref_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q     <= '0;
      qry_q     <= '0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      ref_q <= ref_d;
      qry_q <= qry_d;
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_d;
    end
  end

endmodule

// File: rtl/cigar_interval_walk.sv
// cigar_interval_walk: turns packed cigar words into reference and query intervals
// input side is a queue: drive the word on the input ports and raise push; it is
// taken at a clock edge where push is high and full is low
// cmd begin loads ref start, strand, unclip mode and read length; cmd count adds
// to the query start during the reverse unclip pre-pass; cmd walk emits one interval
// result side is a queue too: while empty is low the oldest interval is on the
// result ports, and it is taken at an edge where pop is high
// the front decodes each word and keeps the strand and unclip flags, a four-word
// queue feeds the back, which owns the two running positions and a two-entry
// result queue
// throughput: one word per cycle while full is low, set by the saturating add/select
// loop on the running positions in the back
// a taken walk word is written into the middle queue and then into the result
// queue, from where it shows on the result ports
// when pop stays low the result queue fills, the back holds walk words, the
// middle queue fills and full rises; begin and count words at the queue head keep draining
// reset clears both positions, both flags and every queue
module cigar_interval_walk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                cmd_i,
  input  logic [31:0]               cigar_word_i,
  input  logic [ciw_pkg::PosW-1:0]  align_ref_start_i,
  input  logic                      align_reverse_i,
  input  logic                      unclip_mode_i,
  input  logic [ciw_pkg::PosW-1:0]  read_length_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [ciw_pkg::CodeW-1:0] op_code_o,
  output logic [ciw_pkg::LenW-1:0]  op_length_o,
  output logic [ciw_pkg::PosW-1:0]  ref_from_o,
  output logic [ciw_pkg::PosW-1:0]  ref_to_o,
  output logic [ciw_pkg::PosW-1:0]  query_from_o,
  output logic [ciw_pkg::PosW-1:0]  query_to_o,
  output logic                      strand_reverse_o
);

  logic             in_accept;
  logic             front_keep;
  ciw_pkg::entry_t  front_entry;
  ciw_pkg::entry_t  back_entry;
  logic             q_empty;
  logic             q_pop;
  ciw_pkg::result_t res;

  // full comes straight from the middle queue count
  assign in_accept = push && !full;

  ciw_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_accept),
    .cmd_i             (cmd_i),
    .cigar_word_i      (cigar_word_i),
    .align_ref_start_i (align_ref_start_i),
    .align_reverse_i   (align_reverse_i),
    .unclip_mode_i     (unclip_mode_i),
    .read_length_i     (read_length_i),
    .keep_o            (front_keep),
    .entry_o           (front_entry)
  );

  // dropped words (ignored counts, unused cmd) never enter the queue
  ciw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && front_keep),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (back_entry)
  );

  ciw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .entry_i   (back_entry),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign op_code_o        = res.op_code;
  assign op_length_o      = res.op_length;
  assign ref_from_o       = res.ref_from;
  assign ref_to_o         = res.ref_to;
  assign query_from_o     = res.query_from;
  assign query_to_o       = res.query_to;
  assign strand_reverse_o = res.strand_reverse;

`ifndef SYNTHESIS
  // query bounds leave in ascending order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (query_from_o <= query_to_o))
    else $error("query interval out of order");

  // the reference position only moves forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (ref_from_o <= ref_to_o))
    else $error("reference interval out of order");

  // a hard clip that leaves as a hard clip never moves the query position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && op_code_o == ciw_pkg::CodeHardClip) |-> (query_from_o == query_to_o))
    else $error("hard clip moved the query position");
`endif

endmodule
